### design/drs_pkg.sv
package drs_pkg;

  localparam int SECTOR_BITS     = 48;
  localparam int CHUNKS_PER_ITEM = 64;
  localparam int CNT_W           = 23;
  localparam int MAX_W           = 32;
  localparam int STATUS_W        = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int K_W             = $clog2(CHUNKS_PER_ITEM + 1);

  localparam logic [CNT_W-1:0] LIMIT_CLAMP = '1;

  // remainder unit: bits retired per cycle
  localparam int DIV_RADIX  = 4;
  localparam int DIV_STEPS  = (SECTOR_BITS + DIV_RADIX - 1) / DIV_RADIX;
  localparam int DIV_W      = DIV_STEPS * DIV_RADIX;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam int PC_W = 5;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNSUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOPEND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEC_EN = 3'd4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LIMITS,
    OP_DIV_MAX,
    OP_FIX_MAX,
    OP_DIV_ALIGN,
    OP_FIX_ALIGN,
    OP_REQ,
    OP_END,
    OP_DIV_CUT,
    OP_CUT,
    OP_EMIT_CHUNK,
    OP_EMIT_UNSUP,
    OP_EMIT_NOPEND,
    OP_EMIT_ZERO
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_KIND_CONT,
    C_NOT_PENDING,
    C_UNSUP,
    C_MAX_ZERO,
    C_LEFT_ZERO,
    C_DIV_BUSY,
    C_NO_SPLIT,
    C_OUT_FULL,
    C_MORE_CHUNKS
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    op_t op;
  } ctl_t;

  typedef struct packed {
    logic no_input;
    logic kind_cont;
    logic not_pending;
    logic unsup;
    logic max_zero;
    logic left_zero;
    logic div_busy;
    logic no_split;
    logic out_full;
    logic more_chunks;
  } flags_t;

  typedef struct packed {
    logic [CNT_W-1:0] gran;
    logic [CNT_W-1:0] align;
    logic [MAX_W-1:0] maxd;
    logic             en;
    logic             sec_en;
  } cfg_t;

endpackage

### design/drs_in_if.sv
interface drs_in_if import drs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [SECTOR_BITS-1:0] start_sector;
  logic [SECTOR_BITS-1:0] sector_count;
  logic                   secure;

  modport source (output valid, kind, start_sector, sector_count, secure, input ready);
  modport sink (input valid, kind, start_sector, sector_count, secure, output ready);
endinterface

### design/drs_out_if.sv
interface drs_out_if import drs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [SECTOR_BITS-1:0] chunk_sector;
  logic [CNT_W-1:0]       chunk_sectors;
  logic                   chunk_secure;
  logic                   more;
  logic                   last;

  modport source (output valid, status, chunk_sector, chunk_sectors, chunk_secure, more, last,
                  input ready);
  modport sink (input valid, status, chunk_sector, chunk_sectors, chunk_secure, more, last,
                output ready);
endinterface

### design/drs_rem_unit.sv
module drs_rem_unit import drs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             busy,
  output logic [CNT_W-1:0] rem
);

  logic [DIV_W-1:0]     sh;
  logic [CNT_W-1:0]     r;
  logic [CNT_W-1:0]     r_next;
  logic [DIV_CNT_W-1:0] cnt;

  assign busy = (cnt != '0);
  assign rem  = r;

  // restoring remainder, a few dividend bits per cycle
  always_comb begin
    logic [CNT_W:0]   t;
    logic [CNT_W-1:0] acc;
    acc = r;
    for (int i = 0; i < DIV_RADIX; i++) begin
      t = {acc, sh[DIV_W-1-i]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      acc = t[CNT_W-1:0];
    end
    r_next = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh <= dividend;
      r  <= '0;
    end else if (busy) begin
      sh <= sh << DIV_RADIX;
      r  <= r_next;
    end
  end

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("remainder unit not busy after start");
`endif

endmodule

### design/drs_sequencer.sv
module drs_sequencer import drs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output ctl_t   ctl
);

  localparam logic [PC_W-1:0] L_IDLE     = 5'd0;
  localparam logic [PC_W-1:0] L_DECODE   = 5'd1;
  localparam logic [PC_W-1:0] L_CONT     = 5'd3;
  localparam logic [PC_W-1:0] L_LIMITS   = 5'd4;
  localparam logic [PC_W-1:0] L_WAIT_MAX = 5'd6;
  localparam logic [PC_W-1:0] L_WAIT_AL  = 5'd9;
  localparam logic [PC_W-1:0] L_CHUNK    = 5'd11;
  localparam logic [PC_W-1:0] L_WAIT_CUT = 5'd14;
  localparam logic [PC_W-1:0] L_EMIT     = 5'd16;
  localparam logic [PC_W-1:0] L_UNSUP    = 5'd19;
  localparam logic [PC_W-1:0] L_NOPEND   = 5'd21;
  localparam logic [PC_W-1:0] L_ZERO     = 5'd23;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucw_t            word;
  logic            taken;

  function automatic ucw_t ucode(input logic [PC_W-1:0] addr);
    ucw_t w;
    case (addr)
      5'd0:    w = '{OP_ACCEPT,     C_NO_INPUT,    L_IDLE};
      5'd1:    w = '{OP_NOP,        C_KIND_CONT,   L_CONT};
      5'd2:    w = '{OP_NOP,        C_ALWAYS,      L_LIMITS};
      5'd3:    w = '{OP_NOP,        C_NOT_PENDING, L_NOPEND};
      5'd4:    w = '{OP_LIMITS,     C_UNSUP,       L_UNSUP};
      5'd5:    w = '{OP_DIV_MAX,    C_NEXT,        L_IDLE};
      5'd6:    w = '{OP_NOP,        C_DIV_BUSY,    L_WAIT_MAX};
      5'd7:    w = '{OP_FIX_MAX,    C_NEXT,        L_IDLE};
      5'd8:    w = '{OP_DIV_ALIGN,  C_MAX_ZERO,    L_UNSUP};
      5'd9:    w = '{OP_NOP,        C_DIV_BUSY,    L_WAIT_AL};
      5'd10:   w = '{OP_FIX_ALIGN,  C_LEFT_ZERO,   L_ZERO};
      5'd11:   w = '{OP_REQ,        C_NEXT,        L_IDLE};
      5'd12:   w = '{OP_END,        C_NO_SPLIT,    L_EMIT};
      5'd13:   w = '{OP_DIV_CUT,    C_NEXT,        L_IDLE};
      5'd14:   w = '{OP_NOP,        C_DIV_BUSY,    L_WAIT_CUT};
      5'd15:   w = '{OP_CUT,        C_NEXT,        L_IDLE};
      5'd16:   w = '{OP_EMIT_CHUNK, C_OUT_FULL,    L_EMIT};
      5'd17:   w = '{OP_NOP,        C_MORE_CHUNKS, L_CHUNK};
      5'd18:   w = '{OP_NOP,        C_ALWAYS,      L_IDLE};
      5'd19:   w = '{OP_EMIT_UNSUP, C_OUT_FULL,    L_UNSUP};
      5'd20:   w = '{OP_NOP,        C_ALWAYS,      L_IDLE};
      5'd21:   w = '{OP_EMIT_NOPEND, C_OUT_FULL,   L_NOPEND};
      5'd22:   w = '{OP_NOP,        C_ALWAYS,      L_IDLE};
      5'd23:   w = '{OP_EMIT_ZERO,  C_OUT_FULL,    L_ZERO};
      default: w = '{OP_NOP,        C_ALWAYS,      L_IDLE};
    endcase
    return w;
  endfunction

  assign word   = ucode(pc);
  assign ctl.op = word.op;

  always_comb begin
    case (word.cond)
      C_NEXT:        taken = 1'b0;
      C_ALWAYS:      taken = 1'b1;
      C_NO_INPUT:    taken = flags.no_input;
      C_KIND_CONT:   taken = flags.kind_cont;
      C_NOT_PENDING: taken = flags.not_pending;
      C_UNSUP:       taken = flags.unsup;
      C_MAX_ZERO:    taken = flags.max_zero;
      C_LEFT_ZERO:   taken = flags.left_zero;
      C_DIV_BUSY:    taken = flags.div_busy;
      C_NO_SPLIT:    taken = flags.no_split;
      C_OUT_FULL:    taken = flags.out_full;
      C_MORE_CHUNKS: taken = flags.more_chunks;
      default:       taken = 1'b0;
    endcase
    pc_next = taken ? word.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= L_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

`ifndef ASSERT_OFF
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (word.op == OP_ACCEPT && !flags.no_input) |=> pc == L_DECODE)
    else $error("sequencer did not decode an accepted beat");
`endif

endmodule

### design/drs_datapath.sv
module drs_datapath import drs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  ctl_t             ctl,
  output flags_t           flags,
  output logic             div_start,
  output logic [DIV_W-1:0] div_dividend,
  output logic [CNT_W-1:0] div_divisor,
  input  logic             div_busy,
  input  logic [CNT_W-1:0] div_rem,
  drs_in_if.sink           req,
  drs_out_if.source        rsp
);

  logic                   kind_r;
  logic                   pend;
  logic                   psec;
  logic [SECTOR_BITS-1:0] cur;
  logic [SECTOR_BITS-1:0] left;
  logic [CNT_W-1:0]       g;
  logic [CNT_W-1:0]       a;
  logic [CNT_W-1:0]       m;
  logic [CNT_W-1:0]       req_n;
  logic [SECTOR_BITS-1:0] end_sec;
  logic [K_W-1:0]         k;

  logic                   out_valid;
  logic [STATUS_W-1:0]    o_status;
  logic [SECTOR_BITS-1:0] o_sector;
  logic [CNT_W-1:0]       o_sectors;
  logic                   o_secure;
  logic                   o_more;
  logic                   o_last;

  logic                   space;
  logic                   load_out;
  logic [SECTOR_BITS-1:0] left_rest;
  logic                   rest_zero;
  logic                   k_final;
  logic [CNT_W-1:0]       clamp_max;

  assign space     = !out_valid || rsp.ready;
  assign load_out  = space && (ctl.op inside {OP_EMIT_CHUNK, OP_EMIT_UNSUP, OP_EMIT_NOPEND,
                                              OP_EMIT_ZERO});
  assign left_rest = left - SECTOR_BITS'(req_n);
  assign rest_zero = (left_rest == '0);
  assign k_final   = (k == K_W'(CHUNKS_PER_ITEM - 1));
  assign clamp_max = (cfg.maxd < MAX_W'(LIMIT_CLAMP)) ? cfg.maxd[CNT_W-1:0] : LIMIT_CLAMP;

  assign req.ready = (ctl.op == OP_ACCEPT);

  assign rsp.valid         = out_valid;
  assign rsp.status        = o_status;
  assign rsp.chunk_sector  = o_sector;
  assign rsp.chunk_sectors = o_sectors;
  assign rsp.chunk_secure  = o_secure;
  assign rsp.more          = o_more;
  assign rsp.last          = o_last;

  assign div_divisor = g;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    case (ctl.op)
      OP_DIV_MAX: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(m);
      end
      OP_DIV_ALIGN: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(cfg.align);
      end
      OP_DIV_CUT: begin
        // remainder of (end - alignment) gives the distance back to a boundary
        div_start    = 1'b1;
        div_dividend = DIV_W'(end_sec - SECTOR_BITS'(a));
      end
      default: begin
        div_start    = 1'b0;
        div_dividend = '0;
      end
    endcase
  end

  assign flags.no_input    = !req.valid;
  assign flags.kind_cont   = kind_r;
  assign flags.not_pending = !pend;
  assign flags.unsup       = !cfg.en || (psec && !cfg.sec_en);
  assign flags.max_zero    = (m == '0);
  assign flags.left_zero   = (left == '0);
  assign flags.div_busy    = div_busy;
  assign flags.no_split    = (SECTOR_BITS'(req_n) == left);
  assign flags.out_full    = !space;
  assign flags.more_chunks = (left != '0) && (k != K_W'(CHUNKS_PER_ITEM));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      psec      <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (ctl.op)
        OP_ACCEPT: begin
          if (req.valid && !req.kind) begin
            pend <= 1'b0;
            psec <= req.secure;
          end
        end
        OP_FIX_ALIGN: begin
          k <= '0;
        end
        OP_EMIT_CHUNK: begin
          if (space) begin
            k    <= k + 1'b1;
            pend <= !rest_zero;
          end
        end
        OP_EMIT_UNSUP, OP_EMIT_ZERO: begin
          if (space) begin
            pend <= 1'b0;
            psec <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_ACCEPT: begin
        if (req.valid) begin
          kind_r <= req.kind;
          if (!req.kind) begin
            cur  <= req.start_sector;
            left <= req.sector_count;
          end
        end
      end
      OP_LIMITS: begin
        g <= (cfg.gran == '0) ? CNT_W'(1) : cfg.gran;
        m <= clamp_max;
      end
      OP_FIX_MAX: begin
        m <= m - div_rem;
      end
      OP_FIX_ALIGN: begin
        a <= div_rem;
      end
      OP_REQ: begin
        req_n <= (left < SECTOR_BITS'(m)) ? left[CNT_W-1:0] : m;
      end
      OP_END: begin
        end_sec <= cur + SECTOR_BITS'(req_n);
      end
      OP_CUT: begin
        // keep the uncut size when the cut would leave nothing
        if (div_rem < req_n) begin
          req_n   <= req_n - div_rem;
          end_sec <= end_sec - SECTOR_BITS'(div_rem);
        end
      end
      OP_EMIT_CHUNK: begin
        if (space) begin
          o_status  <= ST_OK;
          o_sector  <= cur;
          o_sectors <= req_n;
          o_secure  <= psec;
          o_last    <= rest_zero || k_final;
          o_more    <= !rest_zero && k_final;
          cur       <= end_sec;
          left      <= left_rest;
        end
      end
      OP_EMIT_UNSUP: begin
        if (space) begin
          o_status  <= ST_UNSUP;
          o_sector  <= '0;
          o_sectors <= '0;
          o_secure  <= 1'b0;
          o_more    <= 1'b0;
          o_last    <= 1'b1;
        end
      end
      OP_EMIT_NOPEND: begin
        if (space) begin
          o_status  <= ST_NOPEND;
          o_sector  <= '0;
          o_sectors <= '0;
          o_secure  <= 1'b0;
          o_more    <= 1'b0;
          o_last    <= 1'b1;
        end
      end
      OP_EMIT_ZERO: begin
        if (space) begin
          o_status  <= ST_OK;
          o_sector  <= cur;
          o_sectors <= '0;
          o_secure  <= psec;
          o_more    <= 1'b0;
          o_last    <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_mid_chunk: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.last) |-> (rsp.status == ST_OK && rsp.chunk_sectors != '0))
    else $error("non-final beat is not a non-empty chunk");

  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.chunk_sectors == '0 && !rsp.more && rsp.last))
    else $error("error beat carries chunk data");
`endif

endmodule

### design/discard_range_splitter_core.sv
// Splits discard requests into chunks no larger than the effective maximum discard size,
// with split points pulled back to granularity boundaries. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while the block is idle, and the
// block itself does not enforce this. Each request beat is handled on its own: limit setup
// takes two remainder passes by the granularity, and a chunk that is split and must have its
// end aligned takes one more. A request gives at most 64 chunks. The work is paced by
// the microcoded sequencer, which runs one control step per cycle, and by the shared remainder
// unit, which retires 4 dividend bits per cycle over a 48-bit sector address.
module discard_range_splitter_core import drs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  drs_in_if.sink                req,
  drs_out_if.source             rsp
);

  cfg_t             cfg;
  ctl_t             ctl;
  flags_t           flags;
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [CNT_W-1:0] div_divisor;
  logic             div_busy;
  logic [CNT_W-1:0] div_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gran   <= CNT_W'(1);
      cfg.align  <= '0;
      cfg.maxd   <= '0;
      cfg.en     <= 1'b0;
      cfg.sec_en <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRAN:   cfg.gran   <= cfg_data[CNT_W-1:0];
        CFG_ALIGN:  cfg.align  <= cfg_data[CNT_W-1:0];
        CFG_MAX:    cfg.maxd   <= cfg_data[MAX_W-1:0];
        CFG_EN:     cfg.en     <= cfg_data[0];
        CFG_SEC_EN: cfg.sec_en <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  drs_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  drs_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  drs_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .ctl          (ctl),
    .flags        (flags),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_busy     (div_busy),
    .div_rem      (div_rem),
    .req          (req),
    .rsp          (rsp)
  );

endmodule

### test/discard_range_splitter_core_tb.sv
module discard_range_splitter_core_tb;
  import drs_pkg::*;

  localparam logic KIND_NEW  = 1'b0;
  localparam logic KIND_CONT = 1'b1;

  localparam logic [63:0] SECTOR_MASK = {{(64-SECTOR_BITS){1'b0}}, {SECTOR_BITS{1'b1}}};
  localparam logic [SECTOR_BITS-1:0] SECTOR_TOP = '1;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RAND_PHASES    = 10;
  localparam int RAND_ITEMS     = 230;

  typedef struct packed {
    logic                   kind;
    logic [SECTOR_BITS-1:0] start;
    logic [SECTOR_BITS-1:0] count;
    logic                   secure;
  } discard_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [SECTOR_BITS-1:0] sector;
    logic [CNT_W-1:0]       sectors;
    logic                   secure;
    logic                   more;
    logic                   last;
  } chunk_t;

  class discard_chunk_scoreboard;
    logic [CNT_W-1:0]       gran = 1;
    logic [CNT_W-1:0]       align = 0;
    logic [MAX_W-1:0]       maxd = 0;
    logic                   en = 0;
    logic                   sec_en = 0;
    logic                   pending = 0;
    logic                   pend_secure = 0;
    logic [SECTOR_BITS-1:0] next_sec = 0;
    logic [SECTOR_BITS-1:0] left = 0;
    chunk_t                 chunks_due[$];
    int errors = 0;
    int n_req = 0;
    int n_chunks = 0;
    int n_unsup = 0;
    int n_nopend = 0;
    int n_more = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRAN:   gran = data[CNT_W-1:0];
        CFG_ALIGN:  align = data[CNT_W-1:0];
        CFG_MAX:    maxd = data[MAX_W-1:0];
        CFG_EN:     en = data[0];
        CFG_SEC_EN: sec_en = data[0];
        default: ;
      endcase
    endfunction

    function chunk_t make_chunk(logic [STATUS_W-1:0] st, logic [SECTOR_BITS-1:0] sec,
                                logic [CNT_W-1:0] n, logic s, logic m, logic l);
      return {st, sec, n, s, m, l};
    endfunction

    // effective granule, alignment and chunk limit; zero when discard is refused
    function bit get_limits(input logic sec, output logic [63:0] g, a, m);
      logic [63:0] mx;
      g = 1;
      a = 0;
      m = 0;
      if (!en || (sec && !sec_en)) return 0;
      g = (gran != 0) ? 64'(gran) : 64'd1;
      mx = (maxd < LIMIT_CLAMP) ? 64'(maxd) : 64'(LIMIT_CLAMP);
      mx = mx - mx % g;
      if (mx == 0) return 0;
      a = 64'(align) % g;
      m = mx;
      return 1;
    endfunction

    function void clear_range();
      pending = 0;
      pend_secure = 0;
      next_sec = 0;
      left = 0;
    endfunction

    function void split_range(logic [63:0] g, a, m);
      logic [63:0] req, st, fin, cut, nreq;
      chunk_t c;
      bit have;
      int k;
      have = 0;
      k = 0;
      while (left != 0 && k < CHUNKS_PER_ITEM) begin
        req = (left < m) ? 64'(left) : m;
        st = 64'(next_sec);
        fin = (st + req) & SECTOR_MASK;
        // split point off the grid: pull it back to the previous aligned sector
        if (req < left && fin % g != a) begin
          cut = ((((fin - a) & SECTOR_MASK) / g) * g + a) & SECTOR_MASK;
          nreq = (cut - st) & SECTOR_MASK;
          if (nreq != 0 && nreq <= req) begin
            req = nreq;
            fin = cut;
          end
        end
        left = left - req[SECTOR_BITS-1:0];
        next_sec = fin[SECTOR_BITS-1:0];
        if (have) chunks_due.push_back(c);
        c = make_chunk(ST_OK, st[SECTOR_BITS-1:0], req[CNT_W-1:0], pend_secure, 1'b0, 1'b0);
        have = 1;
        k++;
      end
      if (left != 0) begin
        pending = 1;
        c.more = 1'b1;
      end else begin
        clear_range();
      end
      c.last = 1'b1;
      chunks_due.push_back(c);
    endfunction

    function void note_request(discard_req_t r);
      logic [63:0] g, a, m;
      n_req++;
      if (r.kind == KIND_NEW) begin
        clear_range();
        if (!get_limits(r.secure, g, a, m)) begin
          chunks_due.push_back(make_chunk(ST_UNSUP, '0, '0, 1'b0, 1'b0, 1'b1));
        end else if (r.count == 0) begin
          chunks_due.push_back(make_chunk(ST_OK, r.start, '0, r.secure, 1'b0, 1'b1));
        end else begin
          next_sec = r.start;
          left = r.count;
          pend_secure = r.secure;
          split_range(g, a, m);
        end
      end else if (!pending) begin
        chunks_due.push_back(make_chunk(ST_NOPEND, '0, '0, 1'b0, 1'b0, 1'b1));
      end else if (!get_limits(pend_secure, g, a, m)) begin
        clear_range();
        chunks_due.push_back(make_chunk(ST_UNSUP, '0, '0, 1'b0, 1'b0, 1'b1));
      end else begin
        split_range(g, a, m);
      end
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_chunk(chunk_t got);
      chunk_t exp_c;
      if (chunks_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      exp_c = chunks_due.pop_front();
      compare_field("status", 64'(exp_c.status), 64'(got.status));
      compare_field("chunk_sector", 64'(exp_c.sector), 64'(got.sector));
      compare_field("chunk_sectors", 64'(exp_c.sectors), 64'(got.sectors));
      compare_field("chunk_secure", 64'(exp_c.secure), 64'(got.secure));
      compare_field("more", 64'(exp_c.more), 64'(got.more));
      compare_field("last", 64'(exp_c.last), 64'(got.last));
      case (exp_c.status)
        ST_OK:     n_chunks++;
        ST_UNSUP:  n_unsup++;
        ST_NOPEND: n_nopend++;
        default: ;
      endcase
      if (exp_c.more) n_more++;
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  drs_in_if  req_ch ();
  drs_out_if rsp_ch ();

  discard_range_splitter_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  discard_chunk_scoreboard sb = new();

  bit          gaps_on = 1;
  bit          stalls_on = 1;
  int          sent_items = 0;
  int          n_settings = 0;
  int          quiet_cycles = 0;
  int unsigned chunk_hint = 1;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // result side: stalls in short bursts
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_chunk({rsp_ch.status, rsp_ch.chunk_sector, rsp_ch.chunk_sectors,
                        rsp_ch.chunk_secure, rsp_ch.more, rsp_ch.last});
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [SECTOR_BITS-1:0] rand_sector();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[SECTOR_BITS-1:0];
  endfunction

  function automatic discard_req_t new_req(logic [SECTOR_BITS-1:0] start,
                                           logic [SECTOR_BITS-1:0] count, logic secure);
    return {KIND_NEW, start, count, secure};
  endfunction

  // fields other than kind are don't-care on a continue, so they carry noise
  function automatic discard_req_t continue_req();
    return {KIND_CONT, rand_sector(), rand_sector(), 1'($urandom_range(0, 1))};
  endfunction

  function automatic discard_req_t random_new_req();
    logic [SECTOR_BITS-1:0] start, count;
    case ($urandom_range(0, 3))
      0, 1:    start = rand_sector();
      2:       start = SECTOR_BITS'($urandom_range(0, 1000));
      default: start = SECTOR_TOP - SECTOR_BITS'($urandom_range(0, 4 * chunk_hint));
    endcase
    case ($urandom_range(0, 19))
      0, 1:           count = '0;
      2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12:
                      count = SECTOR_BITS'($urandom_range(1, 4 * chunk_hint));
      13, 14, 15, 16: count = SECTOR_BITS'($urandom_range(4 * chunk_hint, 80 * chunk_hint));
      17, 18:         count = rand_sector();
      default:        count = '1;
    endcase
    return new_req(start, count, $urandom_range(0, 3) == 0);
  endfunction

  task automatic send_request(discard_req_t r);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_ch.valid        = 1'b1;
    req_ch.kind         = r.kind;
    req_ch.start_sector = r.start;
    req_ch.sector_count = r.count;
    req_ch.secure       = r.secure;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(r);
    sent_items++;
    @(negedge clk);
  endtask

  // hold off new beats until every chunk owed has come back
  task automatic drain();
    req_ch.valid = 1'b0;
    while (sb.chunks_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_regs(logic [CNT_W-1:0] g, logic [CNT_W-1:0] a, logic [MAX_W-1:0] m,
                          logic e, logic s);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(CFG_GRAN, CFG_DATA_W'(g));
    write_reg(CFG_ALIGN, CFG_DATA_W'(a));
    write_reg(CFG_MAX, CFG_DATA_W'(m));
    write_reg(CFG_EN, CFG_DATA_W'(e));
    write_reg(CFG_SEC_EN, CFG_DATA_W'(s));
    cfg_we = 1'b0;
    chunk_hint = (m == 0) ? 1 : ((m < LIMIT_CLAMP) ? m : LIMIT_CLAMP);
    n_settings++;
  endtask

  task automatic random_config(int p);
    logic [CNT_W-1:0] g, a;
    logic [MAX_W-1:0] m;
    case ($urandom_range(0, 4))
      0:       g = '0;
      1:       g = 1;
      2:       g = CNT_W'($urandom_range(2, 64));
      3:       g = CNT_W'($urandom);
      default: g = '1;
    endcase
    case ($urandom_range(0, 3))
      0:       a = '0;
      1:       a = CNT_W'($urandom_range(0, 63));
      2:       a = CNT_W'($urandom);
      default: a = '1;
    endcase
    // a huge granule wants a huge limit, or nearly everything is refused
    case ((g > 64) ? $urandom_range(6, 9) : $urandom_range(0, 9))
      0:          m = '0;
      1, 2, 3:    m = $urandom_range(1, 200);
      4, 5:       m = $urandom_range(200, 5000);
      6, 7:       m = $urandom;
      8:          m = '1;
      default:    m = MAX_W'(LIMIT_CLAMP);
    endcase
    if (p == 0) begin
      g = '1;
      a = '1;
      m = '1;
    end
    set_regs(g, a, m, $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
  endtask

  // a fresh range, then usually a few continues to walk it
  task automatic send_sequence();
    send_request(random_new_req());
    repeat ($urandom_range(0, 3)) send_request(continue_req());
  endtask

  initial begin
    int p;
    int target;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = CFG_GRAN;
    cfg_data            = '0;
    req_ch.valid        = 1'b0;
    req_ch.kind         = KIND_NEW;
    req_ch.start_sector = '0;
    req_ch.sector_count = '0;
    req_ch.secure       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: discard off, and nothing pending yet
    send_request(new_req('0, 8, 1'b0));
    send_request(continue_req());

    set_regs(8, 3, 100, 1'b1, 1'b0);
    send_request(new_req(0, 10, 1'b1));
    send_request(new_req(SECTOR_TOP, 0, 1'b0));
    send_request(new_req(5, 1000, 1'b0));
    send_request(new_req('0, SECTOR_TOP, 1'b0));
    send_request(continue_req());
    send_request(new_req(1000, 50, 1'b0));
    send_request(continue_req());

    // granule zero, alignment and limit at their tops
    set_regs('0, '1, '1, 1'b1, 1'b1);
    send_request(new_req(SECTOR_TOP - 10, 100, 1'b1));
    send_request(new_req('0, SECTOR_TOP, 1'b1));

    // discard switched off under a pending range
    set_regs('0, '1, '1, 1'b0, 1'b1);
    send_request(continue_req());
    send_request(continue_req());

    // wrap past the top sector with split points pulled back
    set_regs(16, 5, 40, 1'b1, 1'b1);
    send_request(new_req(SECTOR_TOP - 15, 200, 1'b0));
    send_request(new_req(7, 1, 1'b1));

    // limit rounds down to zero granules
    set_regs(16, 5, 10, 1'b1, 1'b1);
    send_request(new_req(100, 100, 1'b0));

    set_regs('1, 1, '1, 1'b1, 1'b1);
    send_request(new_req('0, 3 * 8388607 + 5, 1'b0));
    send_request(new_req(SECTOR_TOP, SECTOR_TOP, 1'b1));
    send_request(continue_req());

    // limits change under a pending secure range, then secure support goes away
    set_regs(4, 2, 20, 1'b1, 1'b1);
    send_request(continue_req());
    send_request(new_req('0, 0, 1'b0));
    send_request(new_req(SECTOR_TOP - 3, SECTOR_TOP, 1'b1));
    set_regs(4, 2, 20, 1'b1, 1'b0);
    send_request(continue_req());

    for (p = 0; p < RAND_PHASES; p++) begin
      random_config(p);
      gaps_on   = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      stalls_on = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      target = sent_items + RAND_ITEMS / RAND_PHASES;
      while (sent_items < target) begin
        if ($urandom_range(0, 9) == 0) send_request(continue_req());
        else send_sequence();
      end
    end

    drain();
    repeat (60) @(posedge clk);

    $display("covered %0d requests over %0d register settings", sb.n_req, n_settings);
    $display("seen %0d chunks (%0d left a range open), %0d refused, %0d idle continues",
             sb.n_chunks, sb.n_more, sb.n_unsup, sb.n_nopend);
    if (sb.errors == 0 && sb.chunks_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
